@@ rtl/lslf_pkg.sv @@
package lslf_pkg;

  localparam int CNT_W   = 13;
  localparam int XY_W    = 16;
  localparam int SUM_W   = 29;
  localparam int PROD_W  = 45;
  localparam int RES_W   = 32;
  localparam int WIDE_W  = 64;
  localparam int QDEPTH  = 2;
  localparam int MUL_A_W = 45;
  localparam int MUL_B_W = 29;
  localparam int DIV_N_W = 74;
  localparam int DIV_D_W = 56;
  localparam int DIV_Q_W = 34;

  typedef struct packed {
    logic [CNT_W-1:0]         n;
    logic signed [SUM_W-1:0]  sx;
    logic signed [SUM_W-1:0]  sy;
    logic signed [PROD_W-1:0] sxy;
    logic signed [PROD_W-1:0] sxx;
  } fit_sums_t;

endpackage

@@ rtl/least_squares_line_fit_top.sv @@
// Samples: one beat per cycle while in_full is low; a beat enters the two-stage
// multiply-accumulate front. Fit: 5 shift-add products and 2 long divisions (a degenerate
// fit skips the divisions and the last product; a quotient overflow ends its division early).
// The back closes one fit at a time; up to two closed fits wait in the queue.
// Reset: synchronous, active low; clears accumulators, queue, sequencer and result valid.
module least_squares_line_fit_top #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [lslf_pkg::XY_W-1:0]    in_x_value,
  input  logic signed [lslf_pkg::XY_W-1:0]    in_y_value,
  input  logic                                in_last_sample,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [lslf_pkg::RES_W-1:0]   out_slope,
  output logic signed [lslf_pkg::RES_W-1:0]   out_intercept,
  output logic [lslf_pkg::CNT_W-1:0]          out_samples_used,
  output logic                                out_degenerate,
  output logic                                out_saturated
);
  import lslf_pkg::*;

  localparam int QC_W = $clog2(QDEPTH + 1);

  logic             q_push;
  fit_sums_t        q_wdata;
  logic             q_pop;
  fit_sums_t        q_rdata;
  logic [QC_W-1:0]  q_count;
  logic             q_empty;

  lslf_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_x_value     (in_x_value),
    .in_y_value     (in_y_value),
    .in_last_sample (in_last_sample),
    .q_count        (q_count),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  lslf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .count (q_count),
    .empty (q_empty)
  );

  lslf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_data           (q_rdata),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_slope        (out_slope),
    .out_intercept    (out_intercept),
    .out_samples_used (out_samples_used),
    .out_degenerate   (out_degenerate),
    .out_saturated    (out_saturated)
  );

endmodule

@@ rtl/lslf_front.sv @@
module lslf_front #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic signed [lslf_pkg::XY_W-1:0]       in_x_value,
  input  logic signed [lslf_pkg::XY_W-1:0]       in_y_value,
  input  logic                                   in_last_sample,
  input  logic [$clog2(lslf_pkg::QDEPTH+1)-1:0]  q_count,
  output logic                                   q_push,
  output lslf_pkg::fit_sums_t                    q_data
);
  import lslf_pkg::*;

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int QC_W = $clog2(QDEPTH + 1);

  logic                       accept;
  logic                       s1_valid_r;
  logic                       s1_last_r;
  logic signed [XY_W-1:0]     s1_x_r;
  logic signed [XY_W-1:0]     s1_y_r;
  logic signed [2*XY_W-1:0]   s1_xy_r;
  logic signed [2*XY_W-1:0]   s1_xx_r;
  logic [QC_W:0]              q_need;
  logic                       take;
  logic [CW-1:0]              cnt_r, cnt_add, cnt_nxt;
  logic signed [SUM_W-1:0]    sx_r, sx_add, sx_nxt;
  logic signed [SUM_W-1:0]    sy_r, sy_add, sy_nxt;
  logic signed [PROD_W-1:0]   sxy_r, sxy_add, sxy_nxt;
  logic signed [PROD_W-1:0]   sxx_r, sxx_add, sxx_nxt;

  // a pending last beat is pushed this cycle and counts as a used queue slot
  assign q_need  = (QC_W+1)'(q_count) + (QC_W+1)'(s1_valid_r & s1_last_r);
  assign in_full = q_need >= (QC_W+1)'(QDEPTH);
  assign accept  = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r <= in_last_sample;
      s1_x_r    <= in_x_value;
      s1_y_r    <= in_y_value;
      s1_xy_r   <= in_x_value * in_y_value;
      s1_xx_r   <= in_x_value * in_x_value;
    end
  end

  assign take = s1_valid_r && (cnt_r < CW'(MAX_SAMPLES));

  always_comb begin
    cnt_add = cnt_r;
    sx_add  = sx_r;
    sy_add  = sy_r;
    sxy_add = sxy_r;
    sxx_add = sxx_r;
    if (take) begin
      cnt_add = cnt_r + CW'(1);
      sx_add  = sx_r + SUM_W'(s1_x_r);
      sy_add  = sy_r + SUM_W'(s1_y_r);
      sxy_add = sxy_r + PROD_W'(s1_xy_r);
      sxx_add = sxx_r + PROD_W'(s1_xx_r);
    end
  end

  assign q_push     = s1_valid_r && s1_last_r;
  assign q_data.n   = CNT_W'(cnt_add);
  assign q_data.sx  = sx_add;
  assign q_data.sy  = sy_add;
  assign q_data.sxy = sxy_add;
  assign q_data.sxx = sxx_add;

  always_comb begin
    if (q_push) begin
      cnt_nxt = '0;
      sx_nxt  = '0;
      sy_nxt  = '0;
      sxy_nxt = '0;
      sxx_nxt = '0;
    end else begin
      cnt_nxt = cnt_add;
      sx_nxt  = sx_add;
      sy_nxt  = sy_add;
      sxy_nxt = sxy_add;
      sxx_nxt = sxx_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxy_r <= '0;
      sxx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sxy_r <= sxy_nxt;
      sxx_r <= sxx_nxt;
    end
  end

endmodule

@@ rtl/lslf_queue.sv @@
module lslf_queue (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  lslf_pkg::fit_sums_t                    wdata,
  input  logic                                   pop,
  output lslf_pkg::fit_sums_t                    rdata,
  output logic [$clog2(lslf_pkg::QDEPTH+1)-1:0]  count,
  output logic                                   empty
);
  import lslf_pkg::*;

  localparam int PW   = $clog2(QDEPTH);
  localparam int QC_W = $clog2(QDEPTH + 1);

  fit_sums_t        mem_r [QDEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [QC_W-1:0]  count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && (count_r != QC_W'(QDEPTH));
  assign do_pop  = pop && (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign count   = count_r;
  assign empty   = (count_r == '0);

  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + QC_W'(1);
      2'b01:   count_nxt = count_r - QC_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/lslf_mul.sv @@
module lslf_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lslf_pkg::MUL_A_W-1:0]    a,
  input  logic [lslf_pkg::MUL_B_W-1:0]    b,
  output logic                            done,
  output logic [lslf_pkg::WIDE_W-1:0]     product
);
  import lslf_pkg::*;

  localparam int CW = $clog2(MUL_B_W + 1);

  logic [WIDE_W-1:0]  acc_r;
  logic [WIDE_W-1:0]  mcand_r;
  logic [MUL_B_W-1:0] mplier_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MUL_B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= WIDE_W'(a);
      mplier_r <= b;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

@@ rtl/lslf_div.sv @@
module lslf_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lslf_pkg::DIV_N_W-1:0]    dividend,
  input  logic [lslf_pkg::DIV_D_W-1:0]    divisor,
  output logic                            done,
  output logic [lslf_pkg::DIV_Q_W-1:0]    quotient,
  output logic                            overflow
);
  import lslf_pkg::*;

  localparam int CW = $clog2(DIV_Q_W + 1);

  logic [DIV_D_W:0]   hi_ext;
  logic               start_ovf;
  logic [DIV_D_W:0]   trial;
  logic               ge;
  logic [DIV_D_W-1:0] rem_nxt;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] d_r;
  logic [DIV_Q_W-1:0] lo_r;
  logic [DIV_Q_W-1:0] q_r;
  logic               ovf_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;

  // quotient needs more than DIV_Q_W bits when the top part already reaches the divisor
  assign hi_ext    = (DIV_D_W+1)'(dividend[DIV_N_W-1:DIV_Q_W]);
  assign start_ovf = hi_ext >= {1'b0, divisor};

  assign trial   = {rem_r, lo_r[DIV_Q_W-1]};
  assign ge      = trial >= {1'b0, d_r};
  assign rem_nxt = ge ? DIV_D_W'(trial - {1'b0, d_r}) : DIV_D_W'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (start_ovf) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CW'(DIV_Q_W);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf_r <= start_ovf;
      d_r   <= divisor;
      rem_r <= DIV_D_W'(hi_ext);
      lo_r  <= dividend[DIV_Q_W-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_r << 1;
      q_r   <= {q_r[DIV_Q_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
  assign overflow = ovf_r;

endmodule

@@ rtl/lslf_back.sv @@
module lslf_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  lslf_pkg::fit_sums_t                 q_data,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [lslf_pkg::RES_W-1:0]   out_slope,
  output logic signed [lslf_pkg::RES_W-1:0]   out_intercept,
  output logic [lslf_pkg::CNT_W-1:0]          out_samples_used,
  output logic                                out_degenerate,
  output logic                                out_saturated
);
  import lslf_pkg::*;

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_MUL_GO     = 4'd1;
  localparam logic [3:0] ST_MUL_WAIT   = 4'd2;
  localparam logic [3:0] ST_CHECK      = 4'd3;
  localparam logic [3:0] ST_DIV_M_GO   = 4'd4;
  localparam logic [3:0] ST_DIV_M_WAIT = 4'd5;
  localparam logic [3:0] ST_DIV_C_PREP = 4'd6;
  localparam logic [3:0] ST_DIV_C_GO   = 4'd7;
  localparam logic [3:0] ST_DIV_C_WAIT = 4'd8;
  localparam logic [3:0] ST_DONE       = 4'd9;

  localparam logic [2:0] P_N_SXY = 3'd0;
  localparam logic [2:0] P_SX_SY = 3'd1;
  localparam logic [2:0] P_N_SXX = 3'd2;
  localparam logic [2:0] P_SX_SX = 3'd3;
  localparam logic [2:0] P_M_SX  = 3'd4;

  localparam int FRAC_SH = 17;
  localparam int SY_SH   = 16;
  localparam int DEN_SH  = 8;
  localparam logic [DIV_Q_W:0] BIG_MAG = (DIV_Q_W+1)'(64'h1_0000_0000);
  localparam logic [DIV_Q_W:0] MIN_MAG = (DIV_Q_W+1)'(64'h8000_0000);
  localparam logic [DIV_Q_W:0] MAX_MAG = (DIV_Q_W+1)'(64'h7FFF_FFFF);

  typedef struct packed {
    logic signed [RES_W-1:0] val;
    logic                    sat;
  } clip_t;

  function automatic clip_t clip_res(input logic neg, input logic [DIV_Q_W:0] mag);
    clip_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > MIN_MAG) begin
        r.val = {1'b1, {(RES_W-1){1'b0}}};
        r.sat = 1'b1;
      end else begin
        r.val = -RES_W'(mag);
      end
    end else begin
      if (mag > MAX_MAG) begin
        r.val = {1'b0, {(RES_W-1){1'b1}}};
        r.sat = 1'b1;
      end else begin
        r.val = RES_W'(mag);
      end
    end
    return r;
  endfunction

  logic [3:0]               state_r, state_nxt;
  logic [2:0]               idx_r, idx_nxt;
  fit_sums_t                sums_r;
  logic signed [WIDE_W-1:0] num_r, num_nxt;
  logic signed [WIDE_W-1:0] den_r, den_nxt;
  logic [WIDE_W-1:0]        mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [RES_W-1:0]  m_r, m_nxt;
  logic signed [RES_W-1:0]  c_r, c_nxt;
  logic                     sat_r, sat_nxt;
  logic                     degen_r, degen_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_load;
  logic signed [RES_W-1:0]  out_slope_r;
  logic signed [RES_W-1:0]  out_intercept_r;
  logic [CNT_W-1:0]         out_samples_r;
  logic                     out_degen_r;
  logic                     out_sat_r;

  logic [SUM_W-1:0]         sx_mag;
  logic [SUM_W-1:0]         sy_mag;
  logic [PROD_W-1:0]        sxy_mag;
  logic [RES_W-1:0]         m_mag;
  logic [WIDE_W-1:0]        num_abs;

  logic                     mul_start;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic                     mul_neg;
  logic                     mul_sub;
  logic                     mul_to_den;
  logic signed [WIDE_W-1:0] mul_base;
  logic                     mul_done;
  logic [WIDE_W-1:0]        mul_p;
  logic signed [WIDE_W-1:0] acc_val;

  logic                     div_start;
  logic [DIV_N_W-1:0]       div_n;
  logic [DIV_D_W-1:0]       div_d;
  logic                     div_done;
  logic [DIV_Q_W-1:0]       div_q;
  logic                     div_ovf;
  logic [DIV_Q_W:0]         q_inc;
  logic [DIV_Q_W:0]         slope_mag;
  logic [DIV_Q_W:0]         icpt_mag;
  clip_t                    clip_m;
  clip_t                    clip_c;

  assign sx_mag  = sums_r.sx[SUM_W-1] ? -sums_r.sx : sums_r.sx;
  assign sy_mag  = sums_r.sy[SUM_W-1] ? -sums_r.sy : sums_r.sy;
  assign sxy_mag = sums_r.sxy[PROD_W-1] ? -sums_r.sxy : sums_r.sxy;
  assign m_mag   = m_r[RES_W-1] ? -m_r : m_r;
  assign num_abs = num_r[WIDE_W-1] ? -num_r : num_r;

  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    mul_neg    = 1'b0;
    mul_sub    = 1'b0;
    mul_to_den = 1'b0;
    mul_base   = '0;
    unique case (idx_r)
      P_N_SXY: begin
        mul_a   = sxy_mag;
        mul_b   = MUL_B_W'(sums_r.n);
        mul_neg = sums_r.sxy[PROD_W-1];
      end
      P_SX_SY: begin
        mul_a    = MUL_A_W'(sy_mag);
        mul_b    = MUL_B_W'(sx_mag);
        mul_neg  = sums_r.sx[SUM_W-1] ^ sums_r.sy[SUM_W-1];
        mul_sub  = 1'b1;
        mul_base = num_r;
      end
      P_N_SXX: begin
        mul_a      = MUL_A_W'($unsigned(sums_r.sxx));
        mul_b      = MUL_B_W'(sums_r.n);
        mul_to_den = 1'b1;
      end
      P_SX_SX: begin
        mul_a      = MUL_A_W'(sx_mag);
        mul_b      = MUL_B_W'(sx_mag);
        mul_sub    = 1'b1;
        mul_to_den = 1'b1;
        mul_base   = den_r;
      end
      P_M_SX: begin
        mul_a    = MUL_A_W'(m_mag);
        mul_b    = MUL_B_W'(sx_mag);
        mul_neg  = m_r[RES_W-1] ^ sums_r.sx[SUM_W-1];
        mul_sub  = 1'b1;
        mul_base = WIDE_W'(sums_r.sy) <<< SY_SH;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign acc_val = (mul_neg ^ mul_sub) ? mul_base - $signed(mul_p)
                                       : mul_base + $signed(mul_p);

  assign mul_start = (state_r == ST_MUL_GO);
  assign div_start = (state_r == ST_DIV_M_GO) || (state_r == ST_DIV_C_GO);

  // slope: num << 17 / den, then round; intercept: (2|num| + 256n) / 512n
  always_comb begin
    if (state_r == ST_DIV_M_GO) begin
      div_n = DIV_N_W'(mag_r) << FRAC_SH;
      div_d = DIV_D_W'(den_r);
    end else begin
      div_n = DIV_N_W'({mag_r, 1'b0}) + (DIV_N_W'(sums_r.n) << DEN_SH);
      div_d = DIV_D_W'(sums_r.n) << (DEN_SH + 1);
    end
  end

  assign q_inc     = (DIV_Q_W+1)'(div_q) + (DIV_Q_W+1)'(1);
  assign slope_mag = div_ovf ? BIG_MAG : (q_inc >> 1);
  assign icpt_mag  = div_ovf ? BIG_MAG : (DIV_Q_W+1)'(div_q);
  assign clip_m    = clip_res(neg_r, slope_mag);
  assign clip_c    = clip_res(neg_r, icpt_mag);

  lslf_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  lslf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q),
    .overflow (div_ovf)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    m_nxt         = m_r;
    c_nxt         = c_r;
    sat_nxt       = sat_r;
    degen_nxt     = degen_r;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          idx_nxt   = P_N_SXY;
          num_nxt   = '0;
          den_nxt   = '0;
          m_nxt     = '0;
          c_nxt     = '0;
          sat_nxt   = 1'b0;
          degen_nxt = 1'b0;
          state_nxt = ST_MUL_GO;
        end
      end
      ST_MUL_GO: begin
        state_nxt = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (mul_to_den) begin
            den_nxt = acc_val;
          end else begin
            num_nxt = acc_val;
          end
          if (idx_r == P_SX_SX) begin
            state_nxt = ST_CHECK;
          end else if (idx_r == P_M_SX) begin
            state_nxt = ST_DIV_C_PREP;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = ST_MUL_GO;
          end
        end
      end
      ST_CHECK: begin
        if (den_r[WIDE_W-1] || (den_r == '0)) begin
          degen_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          mag_nxt   = num_abs;
          neg_nxt   = num_r[WIDE_W-1];
          state_nxt = ST_DIV_M_GO;
        end
      end
      ST_DIV_M_GO: begin
        state_nxt = ST_DIV_M_WAIT;
      end
      ST_DIV_M_WAIT: begin
        if (div_done) begin
          m_nxt     = clip_m.val;
          sat_nxt   = clip_m.sat;
          idx_nxt   = P_M_SX;
          state_nxt = ST_MUL_GO;
        end
      end
      ST_DIV_C_PREP: begin
        mag_nxt   = num_abs;
        neg_nxt   = num_r[WIDE_W-1];
        state_nxt = ST_DIV_C_GO;
      end
      ST_DIV_C_GO: begin
        state_nxt = ST_DIV_C_WAIT;
      end
      ST_DIV_C_WAIT: begin
        if (div_done) begin
          c_nxt     = clip_c.val;
          sat_nxt   = sat_r | clip_c.sat;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= P_N_SXY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    m_r     <= m_nxt;
    c_r     <= c_nxt;
    sat_r   <= sat_nxt;
    degen_r <= degen_nxt;
    if (q_pop) begin
      sums_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slope_r     <= m_r;
      out_intercept_r <= c_r;
      out_samples_r   <= sums_r.n;
      out_degen_r     <= degen_r;
      out_sat_r       <= sat_r;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_slope        = out_slope_r;
  assign out_intercept    = out_intercept_r;
  assign out_samples_used = out_samples_r;
  assign out_degenerate   = out_degen_r;
  assign out_saturated    = out_sat_r;

endmodule

@@ rtl/lslf_checker.sv @@
module lslf_checker #(
  parameter int MAX_SAMPLES = 4096
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_full,
  input logic                                out_empty,
  input logic                                out_pop,
  input logic signed [lslf_pkg::RES_W-1:0]   out_slope,
  input logic signed [lslf_pkg::RES_W-1:0]   out_intercept,
  input logic [lslf_pkg::CNT_W-1:0]          out_samples_used,
  input logic                                out_degenerate,
  input logic                                out_saturated
);
  import lslf_pkg::*;

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_slope)
      && $stable(out_intercept) && $stable(out_samples_used)))
    else $error("result beat changed while stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_degenerate) |->
      (out_slope == '0 && out_intercept == '0 && !out_saturated))
    else $error("degenerate fit with nonzero result");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_samples_used != '0
      && out_samples_used <= CNT_W'(MAX_SAMPLES)))
    else $error("sample count out of range");

  a_reset_state: assert property (@(posedge clk)
    $past(!rst_n) |-> (out_empty && !in_full))
    else $error("block not idle after reset");

endmodule

bind least_squares_line_fit_top lslf_checker #(
  .MAX_SAMPLES (MAX_SAMPLES)
) u_lslf_checker (.*);
